// File: sv/sbt_pkg.sv
`default_nettype none

package sbt_pkg;

  // Table geometry and field widths
  localparam int unsigned ENTRIES_DEF = 16;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned WORD_W      = 32;

  // Trap word after reset
  localparam logic [WORD_W-1:0] TRAP_RESET = 32'h7FE0_0008;

  // Request kinds
  typedef enum logic [1:0] {
    ACT_SET     = 2'd0,
    ACT_REMOVE  = 2'd1,
    ACT_ENABLE  = 2'd2,
    ACT_DISABLE = 2'd3
  } sbt_action_t;

  // Result status codes
  typedef enum logic [1:0] {
    STS_DONE    = 2'd0,
    STS_EXISTS  = 2'd1,
    STS_FULL    = 2'd2,
    STS_MISSING = 2'd3
  } sbt_status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_SCAN = 2'd1,
    ST_EXEC = 2'd2
  } sbt_state_t;

  // One table entry as stored in the RAM
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] saved;
  } sbt_entry_t;

endpackage

`default_nettype wire

// File: sv/sbt_in_if.sv
`default_nettype none

interface sbt_in_if;
  logic                         valid;
  logic                         ready;
  sbt_pkg::sbt_action_t         action;
  logic [sbt_pkg::ADDR_W-1:0]   address;
  logic [sbt_pkg::WORD_W-1:0]   current_word;

  modport source (output valid, action, address, current_word, input ready);
  modport sink   (input valid, action, address, current_word, output ready);
endinterface

`default_nettype wire

// File: sv/sbt_out_if.sv
`default_nettype none

interface sbt_out_if;
  logic                         valid;
  logic                         ready;
  sbt_pkg::sbt_status_t         status;
  logic                         write_enable;
  logic [sbt_pkg::WORD_W-1:0]   write_word;
  logic                         invalidate;

  modport source (output valid, status, write_enable, write_word, invalidate, input ready);
  modport sink   (input valid, status, write_enable, write_word, invalidate, output ready);
endinterface

`default_nettype wire

// File: sv/sbt_ram.sv
`default_nettype none

module sbt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// File: sv/software_breakpoint_table.sv
// Each accepted request scans every table entry before its result beat is loaded.
// Requests are handled one at a time; the table scan reads one
//   entry per cycle through the single read port of the entry RAM.
// The block is busy from accept until its result is loaded into the output register.
// Reset (rst_n low, synchronous) clears all valid marks, the sequencer and the
//   output valid, and loads the trap word with 0x7FE00008; no clearing pass.
`default_nettype none

module software_breakpoint_table #(
  parameter int unsigned ENTRIES = sbt_pkg::ENTRIES_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       cfg_we,
  input  wire logic [sbt_pkg::WORD_W-1:0] cfg_wdata,
  sbt_in_if.sink                          in_chan,
  sbt_out_if.source                       out_chan
);

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(ENTRIES);

  sbt_pkg::sbt_state_t state_r, state_nxt;

  logic [sbt_pkg::WORD_W-1:0] trap_r;
  logic [ENTRIES-1:0]         valid_r;

  // Latched request
  sbt_pkg::sbt_action_t       act_r;
  logic [sbt_pkg::ADDR_W-1:0] addr_r;
  logic [sbt_pkg::WORD_W-1:0] cur_r;

  // Scan pointers and findings
  logic [CNT_W-1:0]           iss_r;
  logic                       cmp_vld_r;
  logic [IDX_W-1:0]           cmp_idx_r;
  logic                       hit_r;
  logic [IDX_W-1:0]           hit_idx_r;
  logic [sbt_pkg::WORD_W-1:0] hit_word_r;
  logic                       free_r;
  logic [IDX_W-1:0]           free_idx_r;

  // Output register
  logic                       out_valid_r;
  sbt_pkg::sbt_status_t       out_status_r;
  logic                       out_we_r;
  logic [sbt_pkg::WORD_W-1:0] out_word_r;
  logic                       out_inval_r;

  // Sequencer outputs
  logic in_ready;
  logic ram_re;
  logic exec_fire;
  logic slot_free;
  logic in_acc;
  logic scan_last;

  // RAM side
  sbt_pkg::sbt_entry_t ram_rdata;
  sbt_pkg::sbt_entry_t ram_wdata;
  logic                ram_we;

  // Result of the current request
  sbt_pkg::sbt_status_t       res_status;
  logic                       res_we;
  logic [sbt_pkg::WORD_W-1:0] res_word;
  logic                       res_inval;
  logic                       res_alloc;
  logic                       res_free;

  assign slot_free = !out_valid_r || out_chan.ready;
  assign in_acc    = in_chan.valid && in_ready;
  assign scan_last = cmp_vld_r && (cmp_idx_r == LAST_IDX);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbt_pkg::ST_IDLE: begin
        if (in_chan.valid) state_nxt = sbt_pkg::ST_SCAN;
      end
      sbt_pkg::ST_SCAN: begin
        if (scan_last) state_nxt = sbt_pkg::ST_EXEC;
      end
      sbt_pkg::ST_EXEC: begin
        if (slot_free) state_nxt = sbt_pkg::ST_IDLE;
      end
      default: state_nxt = sbt_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_re    = 1'b0;
    exec_fire = 1'b0;
    case (state_r)
      sbt_pkg::ST_IDLE: in_ready  = 1'b1;
      sbt_pkg::ST_SCAN: ram_re    = (iss_r < CNT_END);
      sbt_pkg::ST_EXEC: exec_fire = slot_free;
      default: ;
    endcase
  end

  assign in_chan.ready = in_ready;

  // Decide the result from the scan findings
  always_comb begin
    res_status = sbt_pkg::STS_DONE;
    res_we     = 1'b0;
    res_word   = '0;
    res_inval  = 1'b0;
    res_alloc  = 1'b0;
    res_free   = 1'b0;
    if (act_r == sbt_pkg::ACT_SET) begin
      if (hit_r) begin
        res_status = sbt_pkg::STS_EXISTS;
      end else if (!free_r) begin
        res_status = sbt_pkg::STS_FULL;
      end else begin
        res_we    = 1'b1;
        res_word  = trap_r;
        res_inval = 1'b1;
        res_alloc = 1'b1;
      end
    end else if (!hit_r) begin
      res_status = sbt_pkg::STS_MISSING;
    end else begin
      case (act_r)
        sbt_pkg::ACT_REMOVE: begin
          res_we    = 1'b1;
          res_word  = hit_word_r;
          res_inval = 1'b1;
          res_free  = 1'b1;
        end
        sbt_pkg::ACT_ENABLE: begin
          res_we   = 1'b1;
          res_word = trap_r;
        end
        default: begin
          res_we   = 1'b1;
          res_word = hit_word_r;
        end
      endcase
    end
  end

  assign ram_we         = exec_fire && res_alloc;
  assign ram_wdata.addr  = addr_r;
  assign ram_wdata.saved = cur_r;

  sbt_ram #(
    .WIDTH ($bits(sbt_pkg::sbt_entry_t)),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx_r),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (iss_r[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbt_pkg::ST_IDLE;
      trap_r      <= sbt_pkg::TRAP_RESET;
      valid_r     <= '0;
      out_valid_r <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) trap_r <= cfg_wdata;
      // the compare follows in the cycle after the read
      cmp_vld_r <= ram_re;
      if (exec_fire && res_alloc) valid_r[free_idx_r] <= 1'b1;
      if (exec_fire && res_free)  valid_r[hit_idx_r]  <= 1'b0;
      if (exec_fire)              out_valid_r <= 1'b1;
      else if (out_chan.ready)    out_valid_r <= 1'b0;
    end
  end

  // Request latch and scan bookkeeping
  always_ff @(posedge clk) begin
    if (in_acc) begin
      act_r  <= in_chan.action;
      addr_r <= in_chan.address;
      cur_r  <= in_chan.current_word;
      iss_r  <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end else if (state_r == sbt_pkg::ST_SCAN) begin
      if (ram_re) iss_r <= iss_r + CNT_W'(1);
      cmp_idx_r <= iss_r[IDX_W-1:0];
      if (cmp_vld_r) begin
        // keep the first matching valid entry
        if (valid_r[cmp_idx_r] && (ram_rdata.addr == addr_r) && !hit_r) begin
          hit_r      <= 1'b1;
          hit_idx_r  <= cmp_idx_r;
          hit_word_r <= ram_rdata.saved;
        end
        // keep the lowest free entry
        if (!valid_r[cmp_idx_r] && !free_r) begin
          free_r     <= 1'b1;
          free_idx_r <= cmp_idx_r;
        end
      end
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (exec_fire) begin
      out_status_r <= res_status;
      out_we_r     <= res_we;
      out_word_r   <= res_word;
      out_inval_r  <= res_inval;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.write_enable = out_we_r;
  assign out_chan.write_word   = out_word_r;
  assign out_chan.invalidate   = out_inval_r;

endmodule

`default_nettype wire

// File: sv/sbt_checker.sv
`default_nettype none

module sbt_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       in_valid,
  input wire logic                       in_ready,
  input wire logic                       out_valid,
  input wire logic                       out_ready,
  input wire sbt_pkg::sbt_status_t       out_status,
  input wire logic                       out_write_enable,
  input wire logic [sbt_pkg::WORD_W-1:0] out_write_word,
  input wire logic                       out_invalidate
);

  // Busy after taking a request
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while previous one in flight");

  // Result holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_status)
      && $stable(out_write_word)))
    else $error("result dropped or changed while stalled");

  // A write is requested exactly when the request was done
  a_done_writes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_status == sbt_pkg::STS_DONE) == out_write_enable))
    else $error("status and write request disagree");

  // No write means no word and no invalidation
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |-> (out_write_word == '0 && !out_invalidate))
    else $error("stray word or invalidation without write");

endmodule

bind software_breakpoint_table sbt_checker u_sbt_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_chan.valid),
  .in_ready         (in_chan.ready),
  .out_valid        (out_chan.valid),
  .out_ready        (out_chan.ready),
  .out_status       (out_chan.status),
  .out_write_enable (out_chan.write_enable),
  .out_write_word   (out_chan.write_word),
  .out_invalidate   (out_chan.invalidate)
);

`default_nettype wire
